/* sv/dshot_four_channel_frame_encoder_unit_defines.svh */
// assertion macros used by the frame encoder top level
`ifndef DSHOT_FOUR_CHANNEL_FRAME_ENCODER_UNIT_DEFINES_SVH
`define DSHOT_FOUR_CHANNEL_FRAME_ENCODER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define DFE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define DFE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/dfe_pkg.sv */
// shared types, constants and frame functions of the dshot frame encoder
package dfe_pkg;

   localparam int NumCh       = 4;
   localparam int FrameBits   = 16;
   localparam int ThrBits     = 11;
   localparam int PinBits     = 4;
   localparam int SlotBits    = 6;
   localparam int BitIdxBits  = 4;
   localparam int PhaseBits   = 2;
   localparam int WordBits    = 32;

   localparam logic [15:0]          ThrMin     = 16'd48;
   localparam logic [15:0]          ThrMax     = 16'd2047;
   localparam logic [PinBits-1:0]   PinBaseMax = 4'd12;
   localparam logic [SlotBits-1:0]  SlotLast   = 6'd47;

   // phase codes within one frame bit
   localparam logic [PhaseBits-1:0] PhaseLead = 2'd0;
   localparam logic [PhaseBits-1:0] PhaseData = 2'd1;
   localparam logic [PhaseBits-1:0] PhaseTail = 2'd2;

   // register decode on the word address bit
   localparam logic CsrPinBase = 1'b0;

   typedef logic [FrameBits-1:0] frame_type;
   typedef frame_type [NumCh-1:0] frame_set_type;

   typedef struct packed {
      logic          valid;
      frame_set_type frames;
   } frame_bus_type;

   // clamp a raw throttle into the legal command range
   function automatic logic [ThrBits-1:0] clamp_throttle(input logic [15:0] raw);
      logic [15:0] t;
      t = raw;
      if (raw < ThrMin) begin
         t = ThrMin;
      end else if (raw > ThrMax) begin
         t = ThrMax;
      end
      return t[ThrBits-1:0];
   endfunction

   // throttle, zero telemetry bit, nibble xor checksum
   function automatic frame_type make_frame(input logic [ThrBits-1:0] thr);
      logic [11:0] v;
      logic [3:0]  crc;
      v   = {thr, 1'b0};
      crc = v[3:0] ^ v[7:4] ^ v[11:8];
      return {v, crc};
   endfunction

endpackage

/* sv/dfe_csr.sv */
// pin base configuration register behind an apb-style port
module dfe_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [2:0]                    paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready,
   output logic [dfe_pkg::PinBits-1:0]   pin_base
);
   import dfe_pkg::*;

   logic [PinBits-1:0] pin_base_ff;
   logic [PinBits-1:0] pin_base_in;
   logic               wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   // write decode on the low data bits, values above the top legal base are dropped
   always_comb begin
      pin_base_in = pin_base_ff;
      if (wr_en) begin
         unique case (paddr[2])
            CsrPinBase: begin
               if (pwdata[PinBits-1:0] <= PinBaseMax) begin
                  pin_base_in = pwdata[PinBits-1:0];
               end
            end
            default: begin
            end
         endcase
      end
   end

   // read decode
   always_comb begin
      unique case (paddr[2])
         CsrPinBase: prdata = {{(32-PinBits){1'b0}}, pin_base_ff};
         default:    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pin_base_ff <= '0;
      end else begin
         pin_base_ff <= pin_base_in;
      end
   end

   assign pin_base = pin_base_ff;

endmodule

/* sv/dfe_frame_build.sv */
// input register: clamps the four throttles and holds the four frames
module dfe_frame_build (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [15:0]              req_throttle_a,
   input  logic [15:0]              req_throttle_b,
   input  logic [15:0]              req_throttle_c,
   input  logic [15:0]              req_throttle_d,
   input  logic                     frm_release,
   output dfe_pkg::frame_bus_type   frm_bus
);
   import dfe_pkg::*;

   logic          valid_ff;
   logic          valid_in;
   frame_set_type frames_ff;
   frame_set_type frames_in;
   logic          load;

   // take a new item when empty or when the held one finishes this cycle
   assign req_stall = valid_ff && !frm_release;
   assign load      = req_valid && !req_stall;

   always_comb begin
      frames_in[0] = make_frame(clamp_throttle(req_throttle_a));
      frames_in[1] = make_frame(clamp_throttle(req_throttle_b));
      frames_in[2] = make_frame(clamp_throttle(req_throttle_c));
      frames_in[3] = make_frame(clamp_throttle(req_throttle_d));
   end

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (frm_release) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (load) begin
         frames_ff <= frames_in;
      end
   end

   assign frm_bus.valid  = valid_ff;
   assign frm_bus.frames = frames_ff;

endmodule

/* sv/dfe_slot_seq.sv */
// slot sequencer: walks 16 bits by 3 phases and registers each gpio word
module dfe_slot_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  dfe_pkg::frame_bus_type        frm_bus,
   input  logic [dfe_pkg::PinBits-1:0]   pin_base,
   output logic                          frm_release,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [31:0]                   rsp_set_reset_word,
   output logic [5:0]                    rsp_slot_index,
   output logic                          rsp_last_word
);
   import dfe_pkg::*;

   logic [SlotBits-1:0]   slot_ff;
   logic [SlotBits-1:0]   slot_in;
   logic [BitIdxBits-1:0] bit_ff;
   logic [BitIdxBits-1:0] bit_in;
   logic [PhaseBits-1:0]  phase_ff;
   logic [PhaseBits-1:0]  phase_in;
   logic                  out_valid_ff;
   logic                  out_valid_in;
   logic [WordBits-1:0]   word_ff;
   logic [WordBits-1:0]   word_in;
   logic [SlotBits-1:0]   out_slot_ff;
   logic                  out_last_ff;
   logic                  out_free;
   logic                  advance;
   logic                  last_slot;

   assign out_free    = !out_valid_ff || !rsp_stall;
   assign advance     = frm_bus.valid && out_free;
   assign last_slot   = (slot_ff == SlotLast);
   assign frm_release = advance && last_slot;

   // set or reset bit for each channel pin in the current slot
   always_comb begin
      logic [PinBits-1:0] pin;
      logic               data_bit;
      logic               set_it;
      word_in = '0;
      for (int c = 0; c < NumCh; c++) begin
         pin      = pin_base + PinBits'(c);
         data_bit = frm_bus.frames[c][~bit_ff];
         set_it   = (phase_ff == PhaseLead) || ((phase_ff == PhaseData) && data_bit);
         word_in[{!set_it, pin}] = 1'b1;
      end
   end

   // slot, bit and phase counters
   always_comb begin
      slot_in  = slot_ff;
      bit_in   = bit_ff;
      phase_in = phase_ff;
      if (advance) begin
         if (last_slot) begin
            slot_in  = '0;
            bit_in   = '0;
            phase_in = PhaseLead;
         end else if (phase_ff == PhaseTail) begin
            slot_in  = slot_ff + 6'd1;
            bit_in   = bit_ff + 4'd1;
            phase_in = PhaseLead;
         end else begin
            slot_in  = slot_ff + 6'd1;
            phase_in = phase_ff + 2'd1;
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && rsp_stall;
      if (advance) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= '0;
         bit_ff       <= '0;
         phase_ff     <= PhaseLead;
         out_valid_ff <= 1'b0;
      end else begin
         slot_ff      <= slot_in;
         bit_ff       <= bit_in;
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // result register payload
   always_ff @(posedge clock) begin
      if (advance) begin
         word_ff     <= word_in;
         out_slot_ff <= slot_ff;
         out_last_ff <= last_slot;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_set_reset_word = word_ff;
   assign rsp_slot_index     = out_slot_ff;
   assign rsp_last_word      = out_last_ff;

endmodule

/* sv/dshot_four_channel_frame_encoder_unit.sv */
// top level of the four channel dshot frame encoder
//
// req channel: one item carries four 16-bit throttles (channels 0..3), each
// clamped to 48..2047 and packed with a zero telemetry bit and a nibble xor
// checksum into a 16-bit frame.
// rsp channel: 48 gpio set/reset words per item, msb first, three slots per
// frame bit; slot_index counts 0..47 and last_word marks slot 47.
// csr port: pin_base at byte address 0 from pwdata[3:0], values above 12 are ignored.
// datapath: a taken item is held in the frame register, and each word is built
// from it and registered in the result register before it shows on rsp.
// throughput: one word per cycle while rsp is not stalled, set by the slot
// counter; the next item is taken in the cycle the 48th word is registered,
// so items run back to back with no gap.
// stall on rsp holds the result register and the slot counter; req then
// stalls once the frame register is full.
// reset clears pin_base to 0, the frame and result valid flags and the
// slot, bit and phase counters.
module dshot_four_channel_frame_encoder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_throttle_a,
   input  logic [15:0] req_throttle_b,
   input  logic [15:0] req_throttle_c,
   input  logic [15:0] req_throttle_d,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_set_reset_word,
   output logic [5:0]  rsp_slot_index,
   output logic        rsp_last_word,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import dfe_pkg::*;

`include "dshot_four_channel_frame_encoder_unit_defines.svh"

   logic [PinBits-1:0] pin_base;
   frame_bus_type      frm_bus;
   logic               frm_release;

   // configuration register
   dfe_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .pin_base (pin_base)
   );

   // input register with frame build
   dfe_frame_build u_frame_build (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_throttle_a (req_throttle_a),
      .req_throttle_b (req_throttle_b),
      .req_throttle_c (req_throttle_c),
      .req_throttle_d (req_throttle_d),
      .frm_release    (frm_release),
      .frm_bus        (frm_bus)
   );

   // slot sequencer and result register
   dfe_slot_seq u_slot_seq (
      .clock              (clock),
      .reset              (reset),
      .frm_bus            (frm_bus),
      .pin_base           (pin_base),
      .frm_release        (frm_release),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_set_reset_word (rsp_set_reset_word),
      .rsp_slot_index     (rsp_slot_index),
      .rsp_last_word      (rsp_last_word)
   );

   // checks
   `DFE_ASSERT_SAME(a_last_at_end, clock, reset, rsp_valid && rsp_last_word, rsp_slot_index == SlotLast, "last word flagged off the final slot")
   `DFE_ASSERT_NEXT(a_slot_follows, clock, reset, rsp_valid && !rsp_stall && !rsp_last_word, rsp_valid && (rsp_slot_index == $past(rsp_slot_index) + 6'd1), "slot sequence broken inside a frame")
   `DFE_ASSERT_SAME(a_pin_base_range, clock, reset, 1'b1, pin_base <= PinBaseMax, "pin base above legal range")
   `DFE_ASSERT_SAME(a_release_valid, clock, reset, frm_release, frm_bus.valid && !req_stall, "frame released while not held")

endmodule
